// ----- rtl/core/npps_pkg.sv -----
// Shared types, constants and codes of the nearest path point search unit.
package npps_pkg;

	localparam int MAX_POINTS  = 1024;
	localparam int COORD_WIDTH = 24;

	localparam int ADDR_W    = $clog2(MAX_POINTS);
	localparam int IDX_W     = 10;
	localparam int LEN_W     = IDX_W + 1;
	localparam int DIST_W    = 49;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = DIST_W;
	localparam int SQ_W      = 2 * COORD_WIDTH;
	localparam int SUM_W     = SQ_W + 1;
	localparam int EXT_W     = (SUM_W > DIST_W) ? SUM_W : DIST_W;

	localparam logic [DIST_W-1:0] DIST_MAX          = '1;
	localparam logic [DIST_W-1:0] STOP_DIST_RESET   = DIST_W'(1677722);
	localparam logic [LEN_W-1:0]  END_MARGIN_RESET  = LEN_W'(20);
	localparam logic [IDX_W-1:0]  RESTART_IDX_RESET = IDX_W'(2);

	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STOP_DIST   = 2'd0,
		CFG_END_MARGIN  = 2'd1,
		CFG_RESTART_IDX = 2'd2
	} npps_cfg_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} npps_state_t;

	typedef struct packed {
		logic                          action;
		logic [IDX_W-1:0]              point_index;
		logic                          last_point;
		logic signed [COORD_WIDTH-1:0] pos_x;
		logic signed [COORD_WIDTH-1:0] pos_y;
	} npps_in_t;

	typedef struct packed {
		logic [IDX_W-1:0]  best_index;
		logic [DIST_W-1:0] best_distance_sq;
		logic              path_empty;
	} npps_out_t;

	typedef struct packed {
		logic load;
		logic start;
		logic issue;
		logic finish;
	} npps_cmd_t;

	typedef struct packed {
		logic path_empty;
		logic scan_more;
		logic stop_hit;
		logic pipe_busy;
	} npps_stat_t;

endpackage

// ----- rtl/core/npps_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
module npps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/core/npps_ctrl.sv -----
// Controller state machine of the nearest path point search unit.
module npps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                in_action,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	input  npps_pkg::npps_stat_t stat,
	output npps_pkg::npps_cmd_t  cmd
);
	import npps_pkg::*;

	npps_state_t state_q;
	npps_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		in_stall   = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (in_action == ACT_QUERY) begin
						cmd.start = 1'b1;
						state_d   = stat.path_empty ? ST_DONE : ST_SCAN;
					end else begin
						cmd.load = 1'b1;
					end
				end
			end
			ST_SCAN: begin
				if (stat.scan_more && !stat.stop_hit) begin
					cmd.issue = 1'b1;
				end else if (!stat.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/npps_datapath.sv -----
// Datapath: waypoint store, distance pipeline, running minimum and result register.
module npps_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_write,
	input  logic [npps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [npps_pkg::CFG_W-1:0]  cfg_data,
	input  npps_pkg::npps_in_t          in_data,
	input  npps_pkg::npps_cmd_t         cmd,
	output npps_pkg::npps_stat_t        stat,
	output npps_pkg::npps_out_t         out_data
);
	import npps_pkg::*;

	// Configuration registers.
	logic [DIST_W-1:0] stop_dist_q;
	logic [LEN_W-1:0]  end_margin_q;
	logic [IDX_W-1:0]  restart_idx_q;

	// Path and search state.
	logic [LEN_W-1:0]  path_len_q;
	logic [IDX_W-1:0]  goal_q;
	logic [LEN_W-1:0]  scan_q;
	logic              empty_q;
	logic              found_q;
	logic              stop_q;
	logic [DIST_W-1:0] best_q;
	logic [IDX_W-1:0]  best_idx_q;

	logic signed [COORD_WIDTH-1:0] qx_q;
	logic signed [COORD_WIDTH-1:0] qy_q;

	// Distance pipeline.
	logic                   v_s1, v_s2, v_s3, v_s4;
	logic [IDX_W-1:0]       idx_s1, idx_s2, idx_s3, idx_s4;
	logic [COORD_WIDTH-1:0] dx_s2, dy_s2;
	logic [SQ_W-1:0]        sqx_s3, sqy_s3;
	logic [DIST_W-1:0]      d_s4;

	logic                     load_ok;
	logic [2*COORD_WIDTH-1:0] ram_wdata;
	logic [2*COORD_WIDTH-1:0] ram_rdata;
	logic signed [COORD_WIDTH-1:0] wx, wy;
	logic signed [COORD_WIDTH:0]   dfx, dfy;
	logic [EXT_W-1:0]         sum_ext;
	logic [DIST_W-1:0]        sum_sat;
	logic                     take;
	logic [DIST_W-1:0]        best_next;
	logic                     restart_hit;
	logic [IDX_W-1:0]         result_idx;
	npps_out_t                out_q;

	assign load_ok   = cmd.load && (32'(in_data.point_index) < MAX_POINTS);
	assign ram_wdata = {in_data.pos_x, in_data.pos_y};

	npps_ram #(
		.WIDTH(2 * COORD_WIDTH),
		.DEPTH(MAX_POINTS)
	) u_waypoints (
		.clk   (clk),
		.we    (load_ok),
		.waddr (ADDR_W'(in_data.point_index)),
		.wdata (ram_wdata),
		.re    (cmd.issue),
		.raddr (ADDR_W'(scan_q)),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_dist_q   <= STOP_DIST_RESET;
			end_margin_q  <= END_MARGIN_RESET;
			restart_idx_q <= RESTART_IDX_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_STOP_DIST:   stop_dist_q   <= cfg_data[DIST_W-1:0];
				CFG_END_MARGIN:  end_margin_q  <= cfg_data[LEN_W-1:0];
				CFG_RESTART_IDX: restart_idx_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// Absolute coordinate differences; the magnitude always fits COORD_WIDTH bits.
	assign wx  = ram_rdata[2*COORD_WIDTH-1:COORD_WIDTH];
	assign wy  = ram_rdata[COORD_WIDTH-1:0];
	assign dfx = {wx[COORD_WIDTH-1], wx} - {qx_q[COORD_WIDTH-1], qx_q};
	assign dfy = {wy[COORD_WIDTH-1], wy} - {qy_q[COORD_WIDTH-1], qy_q};

	// Sum of squares, saturated to the result width.
	assign sum_ext = EXT_W'(sqx_s3) + EXT_W'(sqy_s3);
	assign sum_sat = (sum_ext > EXT_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(sum_ext);

	// Running minimum: the first scanned point always wins, later ones only if strictly smaller.
	assign take      = v_s4 && !stop_q && (!found_q || (d_s4 < best_q));
	assign best_next = take ? d_s4 : best_q;

	assign restart_hit = (path_len_q >= end_margin_q) &&
	                     ({1'b0, best_idx_q} > (path_len_q - end_margin_q));
	assign result_idx  = restart_hit ? restart_idx_q : best_idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			path_len_q <= '0;
			goal_q     <= '0;
			scan_q     <= '0;
			empty_q    <= 1'b0;
			found_q    <= 1'b0;
			stop_q     <= 1'b0;
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
		end else begin
			if (load_ok && in_data.last_point) begin
				path_len_q <= LEN_W'(in_data.point_index) + LEN_W'(1);
			end
			if (cmd.start) begin
				scan_q  <= LEN_W'(goal_q);
				empty_q <= (path_len_q == '0);
				found_q <= 1'b0;
				stop_q  <= 1'b0;
			end else if (cmd.issue) begin
				scan_q <= scan_q + LEN_W'(1);
			end
			if (v_s4 && !stop_q) begin
				found_q <= 1'b1;
				stop_q  <= (best_next < stop_dist_q);
			end
			if (cmd.finish && !empty_q) begin
				goal_q <= result_idx;
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			qx_q       <= in_data.pos_x;
			qy_q       <= in_data.pos_y;
			best_q     <= DIST_MAX;
			best_idx_q <= '0;
		end else if (take) begin
			best_q     <= d_s4;
			best_idx_q <= idx_s4;
		end
		idx_s1 <= scan_q[IDX_W-1:0];
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		dx_s2  <= dfx[COORD_WIDTH] ? COORD_WIDTH'(-dfx) : COORD_WIDTH'(dfx);
		dy_s2  <= dfy[COORD_WIDTH] ? COORD_WIDTH'(-dfy) : COORD_WIDTH'(dfy);
		sqx_s3 <= SQ_W'(dx_s2) * SQ_W'(dx_s2);
		sqy_s3 <= SQ_W'(dy_s2) * SQ_W'(dy_s2);
		d_s4   <= sum_sat;
		if (cmd.finish) begin
			if (empty_q) begin
				out_q.best_index       <= '0;
				out_q.best_distance_sq <= DIST_MAX;
				out_q.path_empty       <= 1'b1;
			end else begin
				out_q.best_index       <= result_idx;
				out_q.best_distance_sq <= best_q;
				out_q.path_empty       <= 1'b0;
			end
		end
	end

	assign stat.path_empty = (path_len_q == '0);
	assign stat.scan_more  = (scan_q < path_len_q);
	assign stat.stop_hit   = stop_q;
	assign stat.pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	assign out_data        = out_q;

endmodule

// ----- rtl/core/nearest_path_point_search_unit.sv -----
// Top level of the nearest path point search unit: controller plus datapath.
//
// Usage: items arrive on the input channel (in_valid, in_stall, in_data). An
// item with action load writes one waypoint into the path store; when it
// carries last_point the path length becomes point_index + 1. A load produces
// no result. An item with action query scans the stored path from the
// remembered goal index to the path end, one waypoint per cycle, and yields
// one result item on the output channel (out_valid, out_stall, out_data). For
// a non-empty path the result index is also remembered as the next goal
// index. A query that issues waypoint reads loads the output register after
// these steps: the reads are issued, each passes four stages of distance
// pipeline (store read, difference, square, sum) ending in the minimum
// compare, the controller sees the pipeline empty, and it loads the result
// once the output is free. Once the minimum falls below stop_distance_sq no
// new reads start, though reads already issued drain through unused. A query
// whose goal lies at or past the path end issues no reads, and a query on an
// empty path skips the scan, with path_empty set. One query is in work at a
// time; in_stall is high from the accept of a query until its result is in
// the output register. Loads and a new query are taken while an earlier
// result still waits; a second finished result waits in the controller until
// out_stall lets the first one go. Reset clears the path length and the goal
// index and restores the register defaults; waypoint storage is not cleared.
// Registers are written through cfg_write, cfg_index and cfg_data; the user
// must write them only while idle, as the block does not enforce this.
module nearest_path_point_search_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [npps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [npps_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  npps_pkg::npps_in_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output npps_pkg::npps_out_t           out_data
);
	import npps_pkg::*;

	npps_cmd_t  cmd;
	npps_stat_t stat;

	// The controller sequences loads, the scan and the hand-off to the output register.
	npps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_action (in_data.action),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath holds the path, the registers and the distance pipeline.
	npps_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_data  (out_data)
	);

endmodule
